### hdl/mlit_pkg.sv
package mlit_pkg;

   localparam int DIM_X_DEF = 32;
   localparam int DIM_Y_DEF = 32;
   localparam int DIM_Z_DEF = 32;
   localparam int MAX_DIRS_DEF = 64;
   localparam int MAX_LINE_POINTS_DEF = 64;

   localparam int VOL_CAP = 32768;
   localparam int VOL_AW = 15;
   localparam int SUM_W = 40;
   localparam logic [SUM_W-1:0] SAT40 = {SUM_W{1'b1}};

   localparam logic [1:0] KIND_VOXEL = 2'd0;
   localparam logic [1:0] KIND_POINT = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   localparam logic [2:0] REG_NUM_DIRS = 3'd0;
   localparam logic [2:0] REG_RIPPLE = 3'd1;
   localparam logic [2:0] REG_THRESH = 3'd2;
   localparam logic [2:0] REG_LOW_LIMIT = 3'd3;
   localparam logic [2:0] REG_RANGE_FIRST = 3'd4;
   localparam logic [2:0] REG_RANGE_LAST = 3'd5;

   typedef struct packed {
      logic [6:0] num_dirs;
      logic [5:0] ripple_limit;
      logic [15:0] prob_threshold;
      logic [9:0] low_length_limit;
      logic [15:0] range_first;
      logic [15:0] range_last;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_LOAD, ST_DIR, ST_PT_RD, ST_PT_WAIT, ST_VOX_RD, ST_VOX_WAIT,
      ST_ACC, ST_HALF_END, ST_DIR_END, ST_OUT
   } state_type;

   // line point record: dz dy dx weight (37 bits)
   typedef struct packed {
      logic signed [6:0] dz;
      logic signed [6:0] dy;
      logic signed [6:0] dx;
      logic [15:0] w;
   } point_type;

endpackage

### hdl/min_line_integral_thickness_core.sv
// Channel  | Direction | Handshake                  | Payload
// req      | in        | req_tvalid / req_tready    | req_tdata, req_tuser (kind)
// rsp      | out       | rsp_tvalid / rsp_tready    | rsp_tdata
// csr      | in        | psel / penable / pready    | paddr, pwdata, prdata
// A query walks each direction over both halves of its line; for each point the
// point read and then the voxel read each pass through a registered memory.
// After reset a clearing pass zeroes the line lengths; volume and point stores
// are not cleared. One item at a time; the result waits in the output register
// and blocks the next item until taken.
module min_line_integral_thickness_core
   import mlit_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // voxel_index, voxel_value, dir_index, point_index, offset_x, offset_y,
   // offset_z, weight, last_point (bits 0..80), zero fill to 88
   input logic [87:0] req_tdata,
   // kind
   input logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // query_index, min_integral, best_dir, half_integral (bits 0..101), zero fill
   output logic [103:0] rsp_tdata,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [4:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   localparam int DIM_X = DIM_X_DEF;
   localparam int DIM_Y = DIM_Y_DEF;
   localparam int DIM_Z = DIM_Z_DEF;
   localparam int MAX_DIRS = MAX_DIRS_DEF;
   localparam int MAX_LINE_POINTS = MAX_LINE_POINTS_DEF;
   localparam int DW = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
   localparam int PW = (MAX_LINE_POINTS > 1) ? $clog2(MAX_LINE_POINTS) : 1;
   localparam int LW = $clog2(MAX_LINE_POINTS + 1);
   localparam int VSIZE = DIM_X * DIM_Y * DIM_Z;

   cfg_type cfg;

   mlit_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   // input fields
   logic [1:0] kind;
   logic [14:0] in_vi;
   logic [15:0] in_val;
   logic [5:0] in_dir, in_pt;
   point_type in_point;
   logic in_last;
   assign kind = req_tuser;
   assign in_vi = req_tdata[14:0];
   assign in_val = req_tdata[30:15];
   assign in_dir = req_tdata[36:31];
   assign in_pt = req_tdata[42:37];
   assign in_point.dx = req_tdata[49:43];
   assign in_point.dy = req_tdata[56:50];
   assign in_point.dz = req_tdata[63:57];
   assign in_point.w = req_tdata[79:64];
   assign in_last = req_tdata[80];

   state_type state_ff, state_in;
   logic accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid & req_tready;

   // query registers
   logic [14:0] qi_ff, qi_in;
   logic signed [9:0] xm_ff, ym_ff, zm_ff, xm_in, ym_in, zm_in;
   logic [6:0] nd_ff, nd_in;
   logic [DW:0] dir_ff, dir_in;
   logic [LW-1:0] pt_ff, pt_in, len_ff, len_in;
   logic neg_ff, neg_in;
   logic [SUM_W-1:0] sum_ff, sum_in, fwd_ff, fwd_in, best_ff, best_in, half_ff, half_in;
   logic [6:0] bd_ff, bd_in;
   logic [27:0] low_ff, low_in;
   logic down_ff, down_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [15:0] prev_ff, prev_in;
   point_type pnt_ff, pnt_in;
   logic [15:0] v_ff, v_in;
   logic inside_ff, inside_in;
   logic [31:0] prod_ff, prod_in;
   logic [DW:0] clr_ff, clr_in;
   logic [103:0] out_ff, out_in;

   // line length memory, read at the direction about to be walked
   logic len_we;
   logic [DW-1:0] len_wa, len_ra;
   logic [LW-1:0] len_wd, len_rd;
   assign len_ra = dir_in[DW-1:0];

   mlit_mem #(.DEPTH(MAX_DIRS), .WIDTH(LW)) u_lengths (
      .clock, .we(len_we), .waddr(len_wa), .wdata(len_wd), .raddr(len_ra),
      .rdata(len_rd)
   );

   // line point memory
   logic pt_we;
   logic [DW+PW-1:0] pt_wa, pt_ra;
   logic [36:0] pt_rd;
   point_type pt_rd_s;
   assign pt_rd_s = point_type'(pt_rd);

   mlit_mem #(.DEPTH(MAX_DIRS * MAX_LINE_POINTS), .WIDTH(37)) u_points (
      .clock, .we(pt_we), .waddr(pt_wa), .wdata(37'(in_point)), .raddr(pt_ra),
      .rdata(pt_rd)
   );

   // volume memory
   logic vol_we;
   logic [VOL_AW-1:0] vol_ra;
   logic [15:0] vol_rd;

   mlit_mem #(.DEPTH(VOL_CAP), .WIDTH(16)) u_volume (
      .clock, .we(vol_we), .waddr(in_vi), .wdata(in_val), .raddr(vol_ra),
      .rdata(vol_rd)
   );

   // walked coordinate
   logic signed [10:0] wx, wy, wz;
   logic [31:0] widx;
   always_comb begin
      if (neg_ff) begin
         wx = 11'(xm_ff) - 11'(pnt_ff.dx);
         wy = 11'(ym_ff) - 11'(pnt_ff.dy);
         wz = 11'(zm_ff) - 11'(pnt_ff.dz);
      end else begin
         wx = 11'(xm_ff) + 11'(pnt_ff.dx);
         wy = 11'(ym_ff) + 11'(pnt_ff.dy);
         wz = 11'(zm_ff) + 11'(pnt_ff.dz);
      end
      widx = (32'(wz) * 32'(DIM_Y) + 32'(wy)) * 32'(DIM_X) + 32'(wx);
   end

   logic [SUM_W:0] sum_add;
   logic [27:0] low_add;
   logic low_stop, rip_stop, rip_fall;
   logic [31:0] vi1;

   always_comb begin
      state_in = state_ff;
      qi_in = qi_ff; xm_in = xm_ff; ym_in = ym_ff; zm_in = zm_ff; nd_in = nd_ff;
      dir_in = dir_ff; pt_in = pt_ff; len_in = len_ff; neg_in = neg_ff;
      sum_in = sum_ff; fwd_in = fwd_ff; best_in = best_ff; half_in = half_ff;
      bd_in = bd_ff; low_in = low_ff; down_in = down_ff; cnt_in = cnt_ff;
      prev_in = prev_ff; pnt_in = pnt_ff; v_in = v_ff; inside_in = inside_ff;
      prod_in = prod_ff; clr_in = clr_ff; out_in = out_ff;
      len_we = 1'b0; len_wa = in_dir[DW-1:0]; len_wd = LW'(in_pt) + LW'(1);
      pt_we = 1'b0; vol_we = 1'b0;
      pt_wa = {in_dir[DW-1:0], in_pt[PW-1:0]};
      pt_ra = {dir_ff[DW-1:0], pt_ff[PW-1:0]};
      vol_ra = widx[VOL_AW-1:0];
      vi1 = 32'(in_vi) + 32'd1;
      sum_add = {1'b0, sum_ff} + (SUM_W+1)'(prod_ff);
      low_add = low_ff + 28'(pnt_ff.w);
      low_stop = 1'b0; rip_stop = 1'b0; rip_fall = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            len_we = 1'b1; len_wa = clr_ff[DW-1:0]; len_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == MAX_DIRS - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (kind)
                  KIND_VOXEL: vol_we = (32'(in_vi) < VSIZE);
                  KIND_POINT: begin
                     if (32'(in_dir) < MAX_DIRS && 32'(in_pt) < MAX_LINE_POINTS) begin
                        pt_we = 1'b1;
                        len_we = in_last;
                     end
                  end
                  KIND_QUERY: begin
                     qi_in = in_vi;
                     out_in = {2'b0, 40'd0, 7'd0, 40'd0, in_vi};
                     if (32'(in_vi) >= VSIZE || vi1 < 32'(cfg.range_first)
                         || vi1 > 32'(cfg.range_last)) begin
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_LOAD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD: begin
            // coordinates by power-of-two division
            xm_in = 10'(32'(qi_ff) % DIM_X);
            ym_in = 10'((32'(qi_ff) / DIM_X) % DIM_Y);
            zm_in = 10'(32'(qi_ff) / (DIM_X * DIM_Y));
            nd_in = (32'(cfg.num_dirs) > MAX_DIRS) ? 7'(MAX_DIRS) : cfg.num_dirs;
            best_in = SAT40; half_in = '0; bd_in = '0; dir_in = '0;
            state_in = ST_DIR;
         end
         ST_DIR: begin
            if (7'(dir_ff) >= nd_ff) begin
               out_in = {2'b0, half_ff, bd_ff, best_ff, qi_ff};
               state_in = ST_OUT;
            end else begin
               len_in = len_rd;
               sum_in = '0; neg_in = 1'b0; pt_in = '0;
               low_in = '0; down_in = 1'b0; cnt_in = '0; prev_in = '0;
               state_in = ST_PT_RD;
            end
         end
         ST_PT_RD: begin
            if (pt_ff >= len_ff || sum_ff >= best_ff) state_in = ST_HALF_END;
            else state_in = ST_PT_WAIT;
         end
         ST_PT_WAIT: begin
            pnt_in = pt_rd_s;
            state_in = ST_VOX_RD;
         end
         ST_VOX_RD: begin
            inside_in = (wx >= 0 && wx < DIM_X && wy >= 0 && wy < DIM_Y && wz >= 0
                         && wz < DIM_Z && widx < VOL_CAP);
            state_in = ST_VOX_WAIT;
         end
         ST_VOX_WAIT: begin
            v_in = inside_ff ? vol_rd : 16'd0;
            prod_in = (inside_ff ? vol_rd : 16'd0) * pnt_ff.w;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in = sum_add[SUM_W] ? SAT40 : sum_add[SUM_W-1:0];
            if (v_ff < cfg.prob_threshold) begin
               low_in = low_add;
               low_stop = low_add > {6'd0, cfg.low_length_limit, 12'd0};
            end
            if (!low_stop && cfg.ripple_limit != 0) begin
               if (down_ff) begin
                  if (v_ff > prev_ff) begin
                     cnt_in = cnt_ff + 1'b1;
                     rip_stop = (cnt_ff + 1'b1) == cfg.ripple_limit;
                  end
               end else if (v_ff < prev_ff) begin
                  cnt_in = cnt_ff + 1'b1;
                  rip_fall = (cnt_ff + 1'b1) == cfg.ripple_limit;
                  if (rip_fall) begin
                     down_in = 1'b1; cnt_in = '0;
                  end
               end
            end
            prev_in = v_ff;
            pt_in = pt_ff + 1'b1;
            state_in = (low_stop || rip_stop) ? ST_HALF_END : ST_PT_RD;
         end
         ST_HALF_END: begin
            if (!neg_ff) begin
               fwd_in = sum_ff; neg_in = 1'b1; pt_in = '0;
               low_in = '0; down_in = 1'b0; cnt_in = '0; prev_in = '0;
               state_in = ST_PT_RD;
            end else begin
               state_in = ST_DIR_END;
            end
         end
         ST_DIR_END: begin
            if (sum_ff < best_ff) begin
               best_in = sum_ff; half_in = fwd_ff; bd_in = 7'(dir_ff) + 7'd1;
            end
            dir_in = dir_ff + 1'b1;
            state_in = ST_DIR;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      qi_ff <= qi_in; xm_ff <= xm_in; ym_ff <= ym_in; zm_ff <= zm_in; nd_ff <= nd_in;
      dir_ff <= dir_in; pt_ff <= pt_in; len_ff <= len_in; neg_ff <= neg_in;
      sum_ff <= sum_in; fwd_ff <= fwd_in; best_ff <= best_in; half_ff <= half_in;
      bd_ff <= bd_in; low_ff <= low_in; down_ff <= down_in; cnt_ff <= cnt_in;
      prev_ff <= prev_in; pnt_ff <= pnt_in; v_ff <= v_in; inside_ff <= inside_in;
      prod_ff <= prod_in; out_ff <= out_in;
   end

`ifndef NO_ASSERTIONS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_best_le: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIR_END) |=> best_ff <= $past(best_ff))
      else $error("minimum grew");
`endif

endmodule

### hdl/mlit_csr.sv
module mlit_csr
   import mlit_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [4:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready,
   output cfg_type cfg
);

   cfg_type cfg_ff, cfg_in;
   logic wr;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[4:2];
   assign cfg = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_NUM_DIRS: cfg_in.num_dirs = csr_pwdata[6:0];
            REG_RIPPLE: cfg_in.ripple_limit = csr_pwdata[5:0];
            REG_THRESH: cfg_in.prob_threshold = csr_pwdata[15:0];
            REG_LOW_LIMIT: cfg_in.low_length_limit = csr_pwdata[9:0];
            REG_RANGE_FIRST: cfg_in.range_first = csr_pwdata[15:0];
            REG_RANGE_LAST: cfg_in.range_last = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{num_dirs: 7'd1, ripple_limit: 6'd0, prob_threshold: 16'd32768,
                     low_length_limit: 10'd1023, range_first: 16'd1,
                     range_last: 16'd32768};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read decode
   always_comb begin
      unique case (idx)
         REG_NUM_DIRS: csr_prdata = {25'd0, cfg_ff.num_dirs};
         REG_RIPPLE: csr_prdata = {26'd0, cfg_ff.ripple_limit};
         REG_THRESH: csr_prdata = {16'd0, cfg_ff.prob_threshold};
         REG_LOW_LIMIT: csr_prdata = {22'd0, cfg_ff.low_length_limit};
         REG_RANGE_FIRST: csr_prdata = {16'd0, cfg_ff.range_first};
         REG_RANGE_LAST: csr_prdata = {16'd0, cfg_ff.range_last};
         default: csr_prdata = 32'd0;
      endcase
   end

endmodule

### hdl/mlit_mem.sv
module mlit_mem
   import mlit_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 37
) (
   input logic clock,
   input logic we,
   input logic [$clog2(DEPTH)-1:0] waddr,
   input logic [WIDTH-1:0] wdata,
   input logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
